### rtl/sfl_pkg.sv
// Shared types and constants for the 3x3 cross sharpening filter.
// Used by every module of the block and by the channel interfaces.
// No dependencies.
package sfl_pkg;

  localparam int MAX_WIDTH_DEF = 512;

  localparam int PIX_W  = 8;
  localparam int COEF_W = 8;
  localparam int DIM_W  = 10;
  localparam int PROD_W = PIX_W + COEF_W + 1;
  localparam int SUM_W  = PROD_W + 3;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int MIN_DIM = 3;
  localparam int MARGIN  = 2;
  localparam int PIX_MAX = (1 << PIX_W) - 1;

  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = DIM_W'(64);
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = DIM_W'(64);
  localparam logic [COEF_W-1:0] RST_COEF_CENTER  = COEF_W'(5);
  localparam logic [COEF_W-1:0] RST_COEF_EDGE    = COEF_W'(8'hff);

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_COEF_CENTER,
    REG_COEF_UP,
    REG_COEF_DOWN,
    REG_COEF_LEFT,
    REG_COEF_RIGHT
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]         image_width;
    logic [DIM_W-1:0]         image_height;
    logic signed [COEF_W-1:0] coef_center;
    logic signed [COEF_W-1:0] coef_up;
    logic signed [COEF_W-1:0] coef_down;
    logic signed [COEF_W-1:0] coef_left;
    logic signed [COEF_W-1:0] coef_right;
  } cfg_t;

  // Per-item control that travels alongside the pixel data.
  typedef struct packed {
    logic valid;
    logic produce;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] down;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
  } taps_t;

endpackage

### rtl/sfl_if.sv
// Valid/ready channel interfaces for the pixel stream and the result stream.
// Depends on sfl_pkg for the field widths.
interface sfl_pix_if;
  logic                      valid;
  logic                      ready;
  logic [sfl_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface sfl_res_if;
  logic                      valid;
  logic                      ready;
  logic [sfl_pkg::PIX_W-1:0] pixel_out;
  logic                      last_of_frame;

  modport source (output valid, output pixel_out, output last_of_frame, input ready);
  modport sink (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

### rtl/sharpen_filter_3x3.sv
// Cross-shaped 3x3 sharpening filter for 8-bit greyscale pixels in raster order. The
// block takes one pixel per clock unless the result stream stalls and puts out one
// clamped result for every interior pixel once its lower-right pixel has passed the
// window, product and result registers; border pixels give no result and the final
// interior pixel of a frame carries last_of_frame. The line buffer holds both previous
// rows in one word per column and sees one read and one write-back per pixel. It is not
// cleared after reset: the first two rows of a frame fill it before any result uses it.
module sharpen_filter_3x3 #(
  parameter int MAX_WIDTH = sfl_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfl_pkg::ADDR_W-1:0]  paddr,
  input  logic [sfl_pkg::DATA_W-1:0]  pwdata,
  output logic [sfl_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  sfl_pix_if.sink                     pixels,
  sfl_res_if.source                   results
);

  sfl_pkg::cfg_t  cfg;
  sfl_pkg::taps_t taps;
  sfl_pkg::ctl_t  s2_ctl;
  logic           en;
  logic           take;

  // The whole pipeline advances whenever the result register is free or being emptied.
  assign en           = !results.valid || results.ready;
  assign take         = pixels.valid && en;
  assign pixels.ready = en;

  sfl_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfl_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .take  (take),
    .pixel (pixels.pixel_in),
    .cfg   (cfg),
    .taps  (taps),
    .ctl   (s2_ctl)
  );

  sfl_mac u_mac (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .cfg           (cfg),
    .taps          (taps),
    .ctl           (s2_ctl),
    .res_valid     (results.valid),
    .pixel_out     (results.pixel_out),
    .last_of_frame (results.last_of_frame)
  );

  // The last pixel of a frame is always an interior pixel, so it must produce a result.
  a_last_produces: assert property (@(posedge clk) disable iff (rst)
    s2_ctl.valid && s2_ctl.last |-> s2_ctl.produce)
    else $error("end-of-frame transaction marked as a border pixel");

  // A stalled result freezes the whole pipeline.
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(s2_ctl))
    else $error("pipeline moved while the result transaction was stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !results.valid && !s2_ctl.valid)
    else $error("result or pipeline valid left set by reset");

endmodule

### rtl/sfl_cfg_regs.sv
// APB-style configuration registers: frame geometry and the five weights.
// Depends on sfl_pkg for the register map and the cfg_t bundle.
module sfl_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfl_pkg::ADDR_W-1:0]  paddr,
  input  logic [sfl_pkg::DATA_W-1:0]  pwdata,
  output logic [sfl_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output sfl_pkg::cfg_t               cfg
);

  sfl_pkg::reg_idx_t idx;
  logic              wr;

  assign pready = 1'b1;
  assign idx    = sfl_pkg::reg_idx_t'(paddr[sfl_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= sfl_pkg::RST_IMAGE_WIDTH;
      cfg.image_height <= sfl_pkg::RST_IMAGE_HEIGHT;
      cfg.coef_center  <= sfl_pkg::RST_COEF_CENTER;
      cfg.coef_up      <= sfl_pkg::RST_COEF_EDGE;
      cfg.coef_down    <= sfl_pkg::RST_COEF_EDGE;
      cfg.coef_left    <= sfl_pkg::RST_COEF_EDGE;
      cfg.coef_right   <= sfl_pkg::RST_COEF_EDGE;
    end else if (wr) begin
      unique case (idx)
        sfl_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[sfl_pkg::DIM_W-1:0];
        sfl_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[sfl_pkg::DIM_W-1:0];
        sfl_pkg::REG_COEF_CENTER:  cfg.coef_center  <= pwdata[sfl_pkg::COEF_W-1:0];
        sfl_pkg::REG_COEF_UP:      cfg.coef_up      <= pwdata[sfl_pkg::COEF_W-1:0];
        sfl_pkg::REG_COEF_DOWN:    cfg.coef_down    <= pwdata[sfl_pkg::COEF_W-1:0];
        sfl_pkg::REG_COEF_LEFT:    cfg.coef_left    <= pwdata[sfl_pkg::COEF_W-1:0];
        sfl_pkg::REG_COEF_RIGHT:   cfg.coef_right   <= pwdata[sfl_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sfl_pkg::REG_IMAGE_WIDTH:
        prdata = sfl_pkg::DATA_W'(cfg.image_width);
      sfl_pkg::REG_IMAGE_HEIGHT:
        prdata = sfl_pkg::DATA_W'(cfg.image_height);
      sfl_pkg::REG_COEF_CENTER:
        prdata = sfl_pkg::DATA_W'(unsigned'(cfg.coef_center));
      sfl_pkg::REG_COEF_UP:
        prdata = sfl_pkg::DATA_W'(unsigned'(cfg.coef_up));
      sfl_pkg::REG_COEF_DOWN:
        prdata = sfl_pkg::DATA_W'(unsigned'(cfg.coef_down));
      sfl_pkg::REG_COEF_LEFT:
        prdata = sfl_pkg::DATA_W'(unsigned'(cfg.coef_left));
      sfl_pkg::REG_COEF_RIGHT:
        prdata = sfl_pkg::DATA_W'(unsigned'(cfg.coef_right));
      default:
        prdata = '0;
    endcase
  end

endmodule

### rtl/sfl_line_buf.sv
// Raster position counters, the shared two-line buffer memory and the 3x3 window.
// Depends on sfl_pkg for cfg_t, ctl_t and taps_t.
module sfl_line_buf #(
  parameter int MAX_WIDTH = sfl_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       take,
  input  logic [sfl_pkg::PIX_W-1:0]  pixel,
  input  sfl_pkg::cfg_t              cfg,
  output sfl_pkg::taps_t             taps,
  output sfl_pkg::ctl_t              ctl
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int VW = (CW + 1 > sfl_pkg::DIM_W) ? CW + 1 : sfl_pkg::DIM_W;
  localparam int RW = sfl_pkg::DIM_W;
  localparam int PW = sfl_pkg::PIX_W;
  localparam logic [VW-1:0] W_MAX = VW'(MAX_WIDTH);
  localparam logic [VW-1:0] W_MIN = VW'(sfl_pkg::MIN_DIM);

  logic [CW-1:0]   col;
  logic [RW-1:0]   row;
  logic [VW-1:0]   w_raw;
  logic [VW-1:0]   w_eff;
  logic [CW-1:0]   col_last;
  logic [CW-1:0]   col_c;
  logic [RW-1:0]   h_eff;
  logic [RW-1:0]   row_last;
  logic [RW-1:0]   row_c;
  logic            last_col;
  logic            last_row;
  logic            produce;

  sfl_pkg::ctl_t   s1_ctl;
  logic [CW-1:0]   s1_col;
  logic [PW-1:0]   s1_pix;

  // Each word holds the row above in the low byte and the row two above in the high byte.
  logic [2*PW-1:0] mem [MAX_WIDTH];
  logic [2*PW-1:0] rd;
  logic [PW-1:0]   win [9];

  always_comb begin
    w_raw = VW'(cfg.image_width);
    if (w_raw < W_MIN) begin
      w_eff = W_MIN;
    end else if (w_raw > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = w_raw;
    end
    col_last = CW'(w_eff - VW'(1));
    // A geometry change can leave the counters past the new edge; pin them to it.
    col_c    = (col >= col_last) ? col_last : col;
    h_eff    = (cfg.image_height < RW'(sfl_pkg::MIN_DIM)) ? RW'(sfl_pkg::MIN_DIM)
                                                          : cfg.image_height;
    row_last = h_eff - RW'(1);
    row_c    = (row >= h_eff) ? row_last : row;
    last_col = (col_c == col_last);
    last_row = (row_c == row_last);
    produce  = (row_c >= RW'(sfl_pkg::MARGIN)) && (col_c >= CW'(sfl_pkg::MARGIN));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (take) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row_c + RW'(1);
      end else begin
        col <= col_c + CW'(1);
        row <= row_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      ctl    <= '0;
    end else if (en) begin
      s1_ctl.valid   <= take;
      s1_ctl.produce <= produce;
      s1_ctl.last    <= last_col && last_row;
      ctl            <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_col <= col_c;
      s1_pix <= pixel;
    end
  end

  // Consecutive pixels share a column only when a geometry change pins the counter, so
  // otherwise the write-back of one item and the read of the next address different words.
  always_ff @(posedge clk) begin
    if (take) begin
      rd <= mem[col_c];
    end
    if (en && s1_ctl.valid) begin
      mem[s1_col] <= {rd[PW-1:0], s1_pix};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '{default: '0};
    end else if (en && s1_ctl.valid) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= rd[2*PW-1:PW];
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= rd[PW-1:0];
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= s1_pix;
    end
  end

  assign taps.center = win[4];
  assign taps.up     = win[1];
  assign taps.down   = win[7];
  assign taps.left   = win[3];
  assign taps.right  = win[5];

endmodule

### rtl/sfl_mac.sv
// Five-tap weighted sum with clamping, and the result register.
// Depends on sfl_pkg for cfg_t, ctl_t and taps_t.
module sfl_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  sfl_pkg::cfg_t              cfg,
  input  sfl_pkg::taps_t             taps,
  input  sfl_pkg::ctl_t              ctl,
  output logic                       res_valid,
  output logic [sfl_pkg::PIX_W-1:0]  pixel_out,
  output logic                       last_of_frame
);

  localparam int PW = sfl_pkg::PIX_W;
  localparam int QW = sfl_pkg::PROD_W;
  localparam int SW = sfl_pkg::SUM_W;

  function automatic logic [PW-1:0] clamp_pix(input logic signed [SW-1:0] s);
    logic [PW-1:0] r;
    if (s < 0) begin
      r = '0;
    end else if (s > SW'(sfl_pkg::PIX_MAX)) begin
      r = PW'(sfl_pkg::PIX_MAX);
    end else begin
      r = s[PW-1:0];
    end
    return r;
  endfunction

  logic signed [QW-1:0] p_c;
  logic signed [QW-1:0] p_u;
  logic signed [QW-1:0] p_d;
  logic signed [QW-1:0] p_l;
  logic signed [QW-1:0] p_r;
  logic signed [SW-1:0] sum;
  sfl_pkg::ctl_t        s3_ctl;

  always_ff @(posedge clk) begin
    if (en) begin
      p_c <= cfg.coef_center * $signed({1'b0, taps.center});
      p_u <= cfg.coef_up     * $signed({1'b0, taps.up});
      p_d <= cfg.coef_down   * $signed({1'b0, taps.down});
      p_l <= cfg.coef_left   * $signed({1'b0, taps.left});
      p_r <= cfg.coef_right  * $signed({1'b0, taps.right});
    end
  end

  assign sum = SW'(p_c) + SW'(p_u) + SW'(p_d) + SW'(p_l) + SW'(p_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl    <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      s3_ctl    <= ctl;
      res_valid <= s3_ctl.valid && s3_ctl.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_out     <= clamp_pix(sum);
      last_of_frame <= s3_ctl.last;
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sharpen_filter_3x3: streams directed and random greyscale
// frames, predicts each sharpened interior pixel and compares it with the result stream.
// Depends on sfl_pkg, the channel interfaces in sfl_if.sv and the RTL top level.
module tb;

  localparam int MAX_W      = sfl_pkg::MAX_WIDTH_DEF;
  localparam int RAND_ITEMS = 560;
  localparam int PIPE_LAT   = 8;
  localparam int LIMIT      = 1000000;

  typedef struct packed {
    logic [sfl_pkg::PIX_W-1:0] pixel_out;
    logic                      last_of_frame;
  } sharp_res_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [sfl_pkg::ADDR_W-1:0] paddr = '0;
  logic [sfl_pkg::DATA_W-1:0] pwdata = '0;
  logic [sfl_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  sfl_pix_if pix_ch ();
  sfl_res_if res_ch ();

  sharpen_filter_3x3 uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixels  (pix_ch),
    .results (res_ch)
  );

  always #5 clk = ~clk;

  // Shadow of the register file, updated per register write, and of the filter state, updated per accepted pixel.
  sfl_pkg::cfg_t             cfg_shadow;
  logic [sfl_pkg::PIX_W-1:0] row_above [MAX_W];
  logic [sfl_pkg::PIX_W-1:0] row_two_above [MAX_W];
  logic [sfl_pkg::PIX_W-1:0] win_px [9] = '{default: '0};
  int unsigned               col_pos = 0;
  int unsigned               row_pos = 0;

  logic [sfl_pkg::PIX_W-1:0] pixel_feed_q [$];
  sharp_res_t                sharpened_q [$];
  int                        mismatches = 0;
  int unsigned               cycle_cnt = 0;
  int                        rand_items = 0;
  int                        src_gap = 0;
  bit                        src_steady = 0;
  int                        snk_stall = 0;
  bit                        snk_steady = 0;

  logic [sfl_pkg::PIX_W-1:0] directed_px [30] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
    8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255,
    8'd10,  8'd20,  8'd30,  8'd40,  8'd50,  8'd60,  8'd70,  8'd80,  8'd90,
    8'd200, 8'd100, 8'd0
  };

  function automatic int eff_width();
    int w;
    w = cfg_shadow.image_width;
    if (w < sfl_pkg::MIN_DIM) w = sfl_pkg::MIN_DIM;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = cfg_shadow.image_height;
    if (h < sfl_pkg::MIN_DIM) h = sfl_pkg::MIN_DIM;
    return h;
  endfunction

  // Pixels still missing from the current frame; valid only while the stream is quiet.
  function automatic int frame_left();
    int w, h, c, r;
    w = eff_width();
    h = eff_height();
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    return (w - c) + (h - 1 - r) * w;
  endfunction

  function automatic void sharpen_step(input logic [sfl_pkg::PIX_W-1:0] p);
    int unsigned               w, h, c, r;
    logic [sfl_pkg::PIX_W-1:0] a, b;
    int                        sum;
    logic                      last_col, last_row;
    sharp_res_t                res;
    w = eff_width();
    h = eff_height();
    c = col_pos;
    r = row_pos;
    // A geometry shrink mid-frame makes the current position the last one.
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    last_col = (c == w - 1);
    last_row = (r == h - 1);
    a = row_above[c];
    b = row_two_above[c];
    row_two_above[c] = a;
    row_above[c] = p;
    win_px[0] = win_px[1]; win_px[1] = win_px[2]; win_px[2] = b;
    win_px[3] = win_px[4]; win_px[4] = win_px[5]; win_px[5] = a;
    win_px[6] = win_px[7]; win_px[7] = win_px[8]; win_px[8] = p;
    if (r >= sfl_pkg::MARGIN && c >= sfl_pkg::MARGIN) begin
      sum = int'($signed(cfg_shadow.coef_center)) * int'(win_px[4])
          + int'($signed(cfg_shadow.coef_up)) * int'(win_px[1])
          + int'($signed(cfg_shadow.coef_down)) * int'(win_px[7])
          + int'($signed(cfg_shadow.coef_left)) * int'(win_px[3])
          + int'($signed(cfg_shadow.coef_right)) * int'(win_px[5]);
      if (sum < 0) sum = 0;
      if (sum > sfl_pkg::PIX_MAX) sum = sfl_pkg::PIX_MAX;
      res.pixel_out = sfl_pkg::PIX_W'(sum);
      res.last_of_frame = last_col && last_row;
      sharpened_q.push_back(res);
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [sfl_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return sfl_pkg::PIX_W'(sfl_pkg::PIX_MAX);
      default: return sfl_pkg::PIX_W'($urandom_range(0, sfl_pkg::PIX_MAX));
    endcase
  endfunction

  task automatic reg_write(input sfl_pkg::reg_idx_t idx,
                           input logic [sfl_pkg::DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      sfl_pkg::REG_IMAGE_WIDTH:  cfg_shadow.image_width = val[sfl_pkg::DIM_W-1:0];
      sfl_pkg::REG_IMAGE_HEIGHT: cfg_shadow.image_height = val[sfl_pkg::DIM_W-1:0];
      sfl_pkg::REG_COEF_CENTER:  cfg_shadow.coef_center = val[sfl_pkg::COEF_W-1:0];
      sfl_pkg::REG_COEF_UP:      cfg_shadow.coef_up = val[sfl_pkg::COEF_W-1:0];
      sfl_pkg::REG_COEF_DOWN:    cfg_shadow.coef_down = val[sfl_pkg::COEF_W-1:0];
      sfl_pkg::REG_COEF_LEFT:    cfg_shadow.coef_left = val[sfl_pkg::COEF_W-1:0];
      sfl_pkg::REG_COEF_RIGHT:   cfg_shadow.coef_right = val[sfl_pkg::COEF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_coefs(input logic [sfl_pkg::COEF_W-1:0] c, u, d, l, r);
    reg_write(sfl_pkg::REG_COEF_CENTER, sfl_pkg::DATA_W'(c));
    reg_write(sfl_pkg::REG_COEF_UP, sfl_pkg::DATA_W'(u));
    reg_write(sfl_pkg::REG_COEF_DOWN, sfl_pkg::DATA_W'(d));
    reg_write(sfl_pkg::REG_COEF_LEFT, sfl_pkg::DATA_W'(l));
    reg_write(sfl_pkg::REG_COEF_RIGHT, sfl_pkg::DATA_W'(r));
  endtask

  task automatic pick_coefs();
    logic [sfl_pkg::COEF_W-1:0] pick [5];
    logic [sfl_pkg::COEF_W-1:0] corner [5];
    int                         mode;
    corner = '{8'h80, 8'h7f, 8'h00, 8'h01, 8'hff};
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 5; i++) begin
      case (mode)
        1: pick[i] = sfl_pkg::COEF_W'($urandom_range(0, 16) - 8);
        2: pick[i] = sfl_pkg::COEF_W'($urandom);
        default: pick[i] = corner[$urandom_range(0, 4)];
      endcase
    end
    if (mode == 0) set_coefs(5, -1, -1, -1, -1);
    else set_coefs(pick[0], pick[1], pick[2], pick[3], pick[4]);
  endtask

  task automatic push_pixels(input int n);
    repeat (n) pixel_feed_q.push_back(rand_pixel());
  endtask

  task automatic push_directed(input int first, input int n);
    for (int i = first; i < first + n; i++) pixel_feed_q.push_back(directed_px[i]);
  endtask

  // Hold the stream until every expected result is back and the pipeline is empty.
  task automatic drain();
    while (pixel_feed_q.size() != 0 || pix_ch.valid || sharpened_q.size() != 0)
      @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  always @(posedge clk) begin : pixel_driver
    if (rst) begin
      pix_ch.valid <= 1'b0;
      pix_ch.pixel_in <= '0;
    end else if (!pix_ch.valid || pix_ch.ready) begin
      if (src_gap != 0) begin
        src_gap--;
        pix_ch.valid <= 1'b0;
      end else if (pixel_feed_q.size() != 0) begin
        pix_ch.valid <= 1'b1;
        pix_ch.pixel_in <= pixel_feed_q.pop_front();
        if ($urandom_range(0, 99) == 0) src_steady = !src_steady;
        src_gap = src_steady ? 0 : gap_len();
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : pixel_monitor
    if (!rst && pix_ch.valid && pix_ch.ready) sharpen_step(pix_ch.pixel_in);
  end

  always @(posedge clk) begin : result_sink
    sharp_res_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (sharpened_q.size() == 0) begin
          $error("unexpected result transaction: pixel_out=%0d last_of_frame=%0b",
                 res_ch.pixel_out, res_ch.last_of_frame);
          mismatches++;
        end else begin
          want = sharpened_q.pop_front();
          if (res_ch.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %0d, actual %0d", want.pixel_out, res_ch.pixel_out);
            mismatches++;
          end
          if (res_ch.last_of_frame !== want.last_of_frame) begin
            $error("last_of_frame: expected %0b, actual %0b",
                   want.last_of_frame, res_ch.last_of_frame);
            mismatches++;
          end
        end
      end
      if ($urandom_range(0, 299) == 0) snk_steady = !snk_steady;
      if (snk_stall != 0) begin
        snk_stall--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if (!snk_steady && $urandom_range(0, 5) == 0) snk_stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int left;
    int nframes;
    bit first;
    cfg_shadow.image_width = sfl_pkg::RST_IMAGE_WIDTH;
    cfg_shadow.image_height = sfl_pkg::RST_IMAGE_HEIGHT;
    cfg_shadow.coef_center = sfl_pkg::RST_COEF_CENTER;
    cfg_shadow.coef_up = sfl_pkg::RST_COEF_EDGE;
    cfg_shadow.coef_down = sfl_pkg::RST_COEF_EDGE;
    cfg_shadow.coef_left = sfl_pkg::RST_COEF_EDGE;
    cfg_shadow.coef_right = sfl_pkg::RST_COEF_EDGE;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Register values below the minimum size act as 3; extreme weights saturate high.
    reg_write(sfl_pkg::REG_IMAGE_WIDTH, 0);
    reg_write(sfl_pkg::REG_IMAGE_HEIGHT, 0);
    set_coefs(127, -128, -128, -128, -128);
    push_directed(0, 9);
    drain();
    // Swapped extremes drive the sum below zero; this also starts a second frame.
    set_coefs(-128, 127, 127, 127, 127);
    push_directed(9, 9);
    drain();
    // Tallest frame, then cut short mid-frame so the current row becomes the last one.
    reg_write(sfl_pkg::REG_IMAGE_WIDTH, 3);
    reg_write(sfl_pkg::REG_IMAGE_HEIGHT, 1023);
    set_coefs(5, -1, -1, -1, -1);
    push_directed(18, 9);
    drain();
    reg_write(sfl_pkg::REG_IMAGE_HEIGHT, 3);
    push_directed(27, 3);
    drain();

    // A row wider than the line buffers is clipped to the maximum width. Narrowing the
    // frame after one full row shows where the block wrapped to the next row.
    reg_write(sfl_pkg::REG_IMAGE_WIDTH, 1023);
    reg_write(sfl_pkg::REG_IMAGE_HEIGHT, $urandom_range(0, sfl_pkg::MIN_DIM));
    pick_coefs();
    push_pixels(MAX_W + 1);
    drain();
    reg_write(sfl_pkg::REG_IMAGE_WIDTH, sfl_pkg::MIN_DIM);
    push_pixels(frame_left());
    drain();

    while (rand_items < RAND_ITEMS) begin
      drain();
      reg_write(sfl_pkg::REG_IMAGE_WIDTH, $urandom_range(0, 10));
      reg_write(sfl_pkg::REG_IMAGE_HEIGHT, $urandom_range(0, 6));
      pick_coefs();
      nframes = $urandom_range(1, 3);
      first = 1;
      repeat (nframes) begin
        left = first ? frame_left() : eff_width() * eff_height();
        first = 0;
        if ($urandom_range(0, 4) == 0) begin
          // Pause mid-frame and shrink the geometry; widening would expose
          // line-buffer entries that were never written.
          push_pixels($urandom_range(1, left - 1));
          rand_items += left;
          drain();
          reg_write(sfl_pkg::REG_IMAGE_WIDTH, $urandom_range(0, eff_width()));
          if ($urandom_range(0, 1) == 0)
            reg_write(sfl_pkg::REG_IMAGE_HEIGHT, $urandom_range(0, 8));
          left = frame_left();
        end else begin
          rand_items += left;
        end
        push_pixels(left);
      end
    end

    drain();
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
